[hw/rtl/drf_pkg.sv]
// types, codes and sizes shared by the duplicate-rejecting record queue
// no dependencies
package drf_pkg;

    localparam int DEPTH     = 8192;
    localparam int KEY_BYTES = 8;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = PTR_W + 1;
    localparam int KEY_W     = 64;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] app_key;
        logic [47:0]      station_addr;
        logic [7:0]       record_kind;
        logic [31:0]      stamp;
    } drf_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] out_key;
        logic [47:0]      out_addr;
        logic [7:0]       out_kind;
        logic [31:0]      out_stamp;
        logic [13:0]      fill_level;
    } drf_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [47:0]      addr;
        logic [7:0]       kind;
        logic [31:0]      stamp;
    } drf_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FETCH,
        ST_RESP
    } drf_state_t;

endpackage

[hw/rtl/drf_key_cmp.sv]
// key compare unit: ascii case-folded byte compare, ends at first shared zero byte
// depends on drf_pkg
module drf_key_cmp
    import drf_pkg::*;
(
    input  logic [KEY_W-1:0] key_a,
    input  logic [KEY_W-1:0] key_b,
    output logic             key_eq
);

    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    always_comb begin
        logic       done;
        logic [7:0] ca;
        logic [7:0] cb;
        done   = 1'b0;
        key_eq = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++) begin
            ca = fold(key_a[8*i +: 8]);
            cb = fold(key_b[8*i +: 8]);
            if (!done) begin
                if (ca != cb) begin
                    key_eq = 1'b0;
                    done   = 1'b1;
                end else if (ca == 8'h00) begin
                    done = 1'b1;
                end
            end
        end
    end

endmodule

[hw/rtl/dedup_record_fifo.sv]
// bounded record queue with duplicate rejection: record memory, scan sequencer, result register
// depends on drf_pkg and drf_key_cmp
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------
//  s_      | s_valid s_ready s_data         | one request item (drf_req_t)
//  m_      | m_valid m_ready m_data         | one result item per request (drf_rsp_t)
//  cfg_    | cfg_valid cfg_ready cfg_data   | capacity limit write, always ready
//
// enqueue: scan, write, result (an empty queue skips scan, a duplicate skips write);
// the scan reads one stored record a cycle, comparing each once its read data is registered.
// dequeue and peek: fetch, result. full, empty and unknown requests go straight to result.
// one request at a time: s_ready is high only while the sequencer is idle.
// a finished result waits in the output register; the next item is taken meanwhile.
// reset clears pointers and occupancy and sets the limit to 8192; record memory is not cleared.
module dedup_record_fifo
    import drf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  drf_req_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output drf_rsp_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data
);

    drf_state_t       state_reg, state_next;
    drf_req_t         req_reg, req_next;
    logic [1:0]       status_reg, status_next;
    logic             rec_sel_reg, rec_sel_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [13:0]      cap_reg;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0] cmp_cnt_reg, cmp_cnt_next;
    logic             vld_reg, vld_next;
    logic             m_valid_reg;
    drf_rsp_t         m_data_reg;

    drf_rec_t         mem [DEPTH];
    drf_rec_t         rd_data_reg;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;

    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] limit;
    logic             is_full;
    logic             is_empty;
    logic             key_eq;
    logic             hit;
    logic             last_cmp;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign limit     = (CNT_W'(cap_reg) < CNT_W'(DEPTH)) ? CNT_W'(cap_reg) : CNT_W'(DEPTH);
    assign is_full   = occ_reg >= limit;
    assign is_empty  = occ_reg == '0;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    drf_key_cmp u_key_cmp (
        .key_a  (rd_data_reg.key),
        .key_b  (req_reg.app_key & KEY_MASK),
        .key_eq (key_eq)
    );

    assign hit      = vld_reg && key_eq && (rd_data_reg.stamp == req_reg.stamp);
    assign last_cmp = (cmp_cnt_reg + CNT_W'(1)) == occ_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.req_type) inside
                        REQ_ENQ: begin
                            if (is_full) begin
                                state_next = ST_RESP;
                            end else if (is_empty) begin
                                state_next = ST_WRITE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_DEQ, REQ_PEEK: begin
                            state_next = is_empty ? ST_RESP : ST_FETCH;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    state_next = ST_RESP;
                end else if (vld_reg && last_cmp) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_RESP;
            end
            ST_FETCH: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and datapath
    always_comb begin
        s_ready       = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = head_reg;
        wr_en         = 1'b0;
        req_next      = req_reg;
        status_next   = status_reg;
        rec_sel_next  = rec_sel_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        occ_next      = occ_reg;
        scan_ptr_next = scan_ptr_reg;
        iss_cnt_next  = iss_cnt_reg;
        cmp_cnt_next  = cmp_cnt_reg;
        vld_next      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                req_next      = s_data;
                rec_sel_next  = 1'b0;
                scan_ptr_next = head_reg;
                iss_cnt_next  = '0;
                cmp_cnt_next  = '0;
                unique case (s_data.req_type) inside
                    REQ_ENQ: begin
                        status_next = is_full ? STAT_FULL : STAT_OK;
                    end
                    REQ_DEQ, REQ_PEEK: begin
                        status_next = is_empty ? STAT_EMPTY : STAT_OK;
                    end
                    default: begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            ST_SCAN: begin
                // reads run one ahead of the compares
                if (iss_cnt_reg < occ_reg) begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_ptr_reg;
                    scan_ptr_next = scan_ptr_reg + PTR_W'(1);
                    iss_cnt_next  = iss_cnt_reg + CNT_W'(1);
                    vld_next      = 1'b1;
                end
                if (vld_reg) begin
                    cmp_cnt_next = cmp_cnt_reg + CNT_W'(1);
                end
                if (hit) begin
                    status_next = STAT_DUP;
                end
            end
            ST_WRITE: begin
                wr_en     = 1'b1;
                tail_next = tail_reg + PTR_W'(1);
                occ_next  = occ_reg + CNT_W'(1);
            end
            ST_FETCH: begin
                rd_en        = 1'b1;
                rec_sel_next = 1'b1;
                if (req_reg.req_type == REQ_DEQ) begin
                    rd_addr   = head_reg;
                    head_next = head_reg + PTR_W'(1);
                    occ_next  = occ_reg - CNT_W'(1);
                end else begin
                    rd_addr = tail_reg - PTR_W'(1);
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            cap_reg     <= 14'd8192;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            vld_reg   <= vld_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        status_reg   <= status_next;
        rec_sel_reg  <= rec_sel_next;
        scan_ptr_reg <= scan_ptr_next;
        iss_cnt_reg  <= iss_cnt_next;
        cmp_cnt_reg  <= cmp_cnt_next;
        if (state_reg == ST_RESP && out_free) begin
            m_data_reg.status     <= status_reg;
            m_data_reg.out_key    <= rec_sel_reg ? rd_data_reg.key   : '0;
            m_data_reg.out_addr   <= rec_sel_reg ? rd_data_reg.addr  : '0;
            m_data_reg.out_kind   <= rec_sel_reg ? rd_data_reg.kind  : '0;
            m_data_reg.out_stamp  <= rec_sel_reg ? rd_data_reg.stamp : '0;
            m_data_reg.fill_level <= 14'(occ_reg);
        end
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= '{key:   req_reg.app_key & KEY_MASK,
                               addr:  req_reg.station_addr,
                               kind:  req_reg.record_kind,
                               stamp: req_reg.stamp};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_ptr_span: assert property (@(posedge aclk) disable iff (!aresetn)
        PTR_W'(tail_reg - head_reg) == occ_reg[PTR_W-1:0])
        else $error("pointer distance disagrees with occupancy");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> cmp_cnt_reg < occ_reg && iss_cnt_reg <= occ_reg)
        else $error("scan ran past stored records");

    a_scan_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && $past(state_reg) == ST_SCAN |-> $stable(occ_reg))
        else $error("occupancy moved during scan");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WRITE |-> !is_full)
        else $error("write into a full queue");

endmodule
